// ----- design/clook_pkg.sv -----
// Package for the C-LOOK request scheduler: sizes, status and function codes,
// and the payload, entry and scan-result structs.
// No dependencies; every other design file imports it.
package clook_pkg;

	localparam int ENTRIES    = 32;
	localparam int TRACK_BITS = 16;
	localparam int TAG_BITS   = 16;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_BITS   = $clog2(ENTRIES + 1);

	localparam logic       FUNC_ADD = 1'b0;
	localparam logic       FUNC_POP = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                  func;
		logic [TRACK_BITS-1:0] track;
		logic [TAG_BITS-1:0]   request_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [TAG_BITS-1:0]   served_tag;
		logic [TRACK_BITS-1:0] served_track;
	} rsp_t;

	typedef struct packed {
		logic [TRACK_BITS-1:0] track;
		logic [TAG_BITS-1:0]   tag;
	} entry_t;

	typedef struct packed {
		logic                  hit;
		logic                  found_above;
		logic [TRACK_BITS-1:0] best_above;
		logic [TRACK_BITS-1:0] best_all;
		logic [IDX_BITS-1:0]   hit_idx;
		logic [IDX_BITS-1:0]   above_idx;
		logic [IDX_BITS-1:0]   all_idx;
	} scan_t;

endpackage

// ----- design/clook_entry_ram.sv -----
// Entry memory of the scheduler: one write port, one read port, registered read data.
// Depends on clook_pkg for the depth and the entry struct.
module clook_entry_ram import clook_pkg::*; (
	input  logic                clk,
	input  logic                we,
	input  logic [IDX_BITS-1:0] waddr,
	input  entry_t              wdata,
	input  logic [IDX_BITS-1:0] raddr,
	output entry_t              rdata
);

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- design/clook_scan_acc.sv -----
// Scan accumulator: takes one entry per cycle and keeps the first entry at the
// head track, the smallest track above the head and the smallest track overall.
// Depends on clook_pkg.
module clook_scan_acc import clook_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  en,
	input  logic                  skip,
	input  logic [IDX_BITS-1:0]   idx,
	input  logic [TRACK_BITS-1:0] trk,
	input  logic [TRACK_BITS-1:0] head,
	output scan_t                 stats
);

	logic                  hit_q;
	logic                  above_q;
	logic                  seen_q;
	logic [TRACK_BITS-1:0] best_above_q;
	logic [TRACK_BITS-1:0] best_all_q;
	logic [IDX_BITS-1:0]   hit_idx_q;
	logic [IDX_BITS-1:0]   above_idx_q;
	logic [IDX_BITS-1:0]   all_idx_q;
	logic                  take;
	logic                  is_hit;
	logic                  is_above;
	logic                  is_all;

	assign take     = en && !skip && !clear;
	assign is_hit   = take && (trk == head) && !hit_q;
	assign is_above = take && (trk > head) && (!above_q || (trk < best_above_q));
	// Strict less keeps the first index of the minimum.
	assign is_all   = take && (!seen_q || (trk < best_all_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			above_q <= 1'b0;
			seen_q  <= 1'b0;
		end else if (clear) begin
			hit_q   <= 1'b0;
			above_q <= 1'b0;
			seen_q  <= 1'b0;
		end else begin
			hit_q   <= hit_q   | is_hit;
			above_q <= above_q | is_above;
			seen_q  <= seen_q  | is_all;
		end
	end

	always_ff @(posedge clk) begin
		if (is_hit) begin
			hit_idx_q <= idx;
		end
		if (is_above) begin
			best_above_q <= trk;
			above_idx_q  <= idx;
		end
		if (is_all) begin
			best_all_q <= trk;
			all_idx_q  <= idx;
		end
	end

	assign stats = '{
		hit:         hit_q,
		found_above: above_q,
		best_above:  best_above_q,
		best_all:    best_all_q,
		hit_idx:     hit_idx_q,
		above_idx:   above_idx_q,
		all_idx:     all_idx_q
	};

endmodule

// ----- design/c_look_request_scheduler_core.sv -----
// C-LOOK request scheduler, top level. An add, or a pop of an empty table, is
// answered by done in the cycle after start is taken, and busy stays low, so such
// transactions can follow each other in every cycle. A pop with pending entries
// keeps busy high while the single read port of the entry memory is swept twice,
// once to find the entry to serve and once to close the gap it leaves while the
// next head track is found; its result comes with done as busy falls. done lasts
// one cycle and cannot be held off.
// Depends on clook_pkg, clook_entry_ram and clook_scan_acc.
module c_look_request_scheduler_core import clook_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_FIND = 2'd1;
	localparam logic [1:0] S_PACK = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [TRACK_BITS-1:0] head_q;
	logic [CNT_BITS-1:0]   rd_ptr_q;
	logic                  valid_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic [IDX_BITS-1:0]   pick_q;
	entry_t                serve_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic                  accept;
	logic                  in_pass;
	logic                  issue;
	logic                  pass_end;
	logic                  full;
	logic                  we;
	logic [IDX_BITS-1:0]   waddr;
	entry_t                wdata;
	entry_t                rdata;
	logic                  clear;
	logic                  skip;
	scan_t                 stats;
	logic [IDX_BITS-1:0]   pick_nxt;
	logic [TRACK_BITS-1:0] head_nxt;
	logic [CNT_BITS-1:0]   count_dec;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign full     = (count_q == CNT_BITS'(ENTRIES));
	assign in_pass  = (state_q == S_FIND) || (state_q == S_PACK);
	assign issue    = in_pass && (rd_ptr_q < count_q);
	assign pass_end = in_pass && !issue && !valid_s1;
	assign count_dec = count_q - CNT_BITS'(1);

	assign clear = (accept && (req.func == FUNC_POP) && (count_q != '0))
		|| ((state_q == S_FIND) && pass_end);
	assign skip  = (state_q == S_PACK) && (idx_s1 == pick_q);

	// Write port: adds in idle, entry moves one slot down while packing.
	always_comb begin
		we    = 1'b0;
		waddr = count_q[IDX_BITS-1:0];
		wdata = '{track: req.track, tag: req.request_tag};
		if (accept && (req.func == FUNC_ADD) && !full) begin
			we = 1'b1;
		end
		if ((state_q == S_PACK) && valid_s1 && (idx_s1 > pick_q)) begin
			we    = 1'b1;
			waddr = idx_s1 - IDX_BITS'(1);
			wdata = rdata;
		end
	end

	// Serve the head track if pending, else advance with wrap.
	always_comb begin
		if (stats.hit) begin
			pick_nxt = stats.hit_idx;
			head_nxt = head_q;
		end else if (stats.found_above) begin
			pick_nxt = stats.above_idx;
			head_nxt = stats.best_above;
		end else begin
			pick_nxt = stats.all_idx;
			head_nxt = stats.best_all;
		end
	end

	clook_entry_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_ptr_q[IDX_BITS-1:0]),
		.rdata (rdata)
	);

	clook_scan_acc u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.en     (valid_s1),
		.skip   (skip),
		.idx    (idx_s1),
		.trk    (rdata.track),
		.head   (head_q),
		.stats  (stats)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			head_q   <= '0;
			rd_ptr_q <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= issue;
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + CNT_BITS'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.func == FUNC_ADD) begin
							done_q <= 1'b1;
							if (!full) begin
								count_q <= count_q + CNT_BITS'(1);
								if (count_q == '0) begin
									head_q <= req.track;
								end
							end
						end else if (count_q == '0) begin
							done_q <= 1'b1;
						end else begin
							rd_ptr_q <= '0;
							state_q  <= S_FIND;
						end
					end
				end
				S_FIND: begin
					if (pass_end) begin
						head_q   <= head_nxt;
						rd_ptr_q <= '0;
						state_q  <= S_PACK;
					end
				end
				S_PACK: begin
					if (pass_end) begin
						count_q <= count_dec;
						// Move the head once its track has no entry left.
						if ((count_dec != '0) && !stats.hit) begin
							head_q <= stats.found_above ? stats.best_above : stats.best_all;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= rd_ptr_q[IDX_BITS-1:0];
		end
		if ((state_q == S_FIND) && pass_end) begin
			pick_q <= pick_nxt;
		end
		if (skip && valid_s1) begin
			serve_q <= rdata;
		end
		if (accept && (req.func == FUNC_ADD)) begin
			rsp_q <= '{status: (full ? ST_FULL : ST_OK), served_tag: '0, served_track: '0};
		end else if (accept && (count_q == '0)) begin
			rsp_q <= '{status: ST_EMPTY, served_tag: '0, served_track: '0};
		end else if ((state_q == S_PACK) && pass_end) begin
			rsp_q <= '{status: ST_OK, served_tag: serve_q.tag, served_track: serve_q.track};
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a pop is in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(ENTRIES))
		else $error("entry count above table depth");

	a_pack_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (state_q == S_PACK)) |-> (CNT_BITS'(waddr) < count_dec))
		else $error("packing write beyond the remaining entries");

	a_pop_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.func == FUNC_POP) && (count_q != '0)) |=> (state_q == S_FIND))
		else $error("pop of a non-empty table did not start the scan");

endmodule
